/* design/gsa_pkg.sv */
package gsa_pkg;

    localparam int CLASS_W           = 3;
    localparam int PROB_W            = 16;
    localparam int NUM_PROBS         = 8;
    localparam int DEF_MAX_CLASSES   = 8;
    localparam int DEF_HISTORY_DEPTH = 8;
    localparam int IN_TDATA_W        = 144;
    localparam int OUT_TDATA_W       = 40;
    localparam int ADDR_W            = 4;

    localparam logic [15:0] HALF_CONF      = 16'd16384;
    localparam logic [3:0]  RST_CLASS_CNT  = 4'd8;
    localparam logic [15:0] RST_MOTION_THR = 16'd0;
    localparam logic [15:0] RST_MIN_CONF   = 16'd16384;
    localparam logic [3:0]  SMOOTH_NONE    = 4'hF;

    localparam logic [1:0] REG_NUM_CLS     = 2'd0;
    localparam logic [1:0] REG_MOTION_THR  = 2'd1;
    localparam logic [1:0] REG_MIN_CONF    = 2'd2;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARGMAX,
        S_WSQ,
        S_MUL,
        S_ACC,
        S_SCAN,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clr;
        logic mul_en;
        logic acc_en;
    } t_lane_ctl;

    typedef struct packed {
        logic        done;
        logic [15:0] q;
    } t_div_res;

endpackage

/* design/gsa_lane.sv */
// One class lane: saturating weighted and plain sums plus its vote count.
module gsa_lane #(
    parameter int LANE_IDX      = 0,
    parameter int HISTORY_DEPTH = gsa_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  gsa_pkg::t_lane_ctl                      i_ctl,
    input  logic [15:0]                             i_prob,
    input  logic [31:0]                             i_weight,
    input  logic [HISTORY_DEPTH-1:0][2:0]           i_hist,
    input  logic [$clog2(HISTORY_DEPTH+1)-1:0]      i_fill,
    output logic [63:0]                             o_wsum,
    output logic [31:0]                             o_psum,
    output logic [$clog2(HISTORY_DEPTH+1)-1:0]      o_votes
);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);

    logic [47:0]   r_prod;
    logic [63:0]   r_wsum;
    logic [31:0]   r_psum;
    logic [64:0]   w_wadd;
    logic [32:0]   w_padd;
    logic [FW-1:0] n_votes;

    assign w_wadd = {1'b0, r_wsum} + 65'(r_prod);
    assign w_padd = {1'b0, r_psum} + 33'(i_prob);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= 48'(i_prob) * 48'(i_weight);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_wsum <= '0;
            r_psum <= '0;
        end else if (i_ctl.acc_en) begin
            r_wsum <= w_wadd[64] ? {64{1'b1}} : w_wadd[63:0];
            r_psum <= w_padd[32] ? {32{1'b1}} : w_padd[31:0];
        end
    end

    always_comb begin
        n_votes = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (FW'(i) < i_fill && i_hist[i] == 3'(LANE_IDX)) begin
                n_votes = n_votes + FW'(1);
            end
        end
    end

    assign o_wsum  = r_wsum;
    assign o_psum  = r_psum;
    assign o_votes = n_votes;
endmodule

/* design/gsa_div.sv */
// Restoring 64-by-64 divider, one quotient bit per cycle; quotient clamps to 16 bits.
module gsa_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [63:0]       i_num,
    input  logic [63:0]       i_den,
    output gsa_pkg::t_div_res o_res
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [64:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_den;
    logic [64:0] w_shift;
    logic        w_ge;

    assign w_shift = {r_rem[63:0], r_quo[63]};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_shift - {1'b0, r_den}) : w_shift;
            r_quo <= {r_quo[62:0], w_ge};
        end
    end

    assign o_res.done = r_done;
    assign o_res.q    = (|r_quo[63:16]) ? 16'hFFFF : r_quo[15:0];
endmodule

/* design/gesture_score_accumulator_core.sv */
// Gesture score accumulator. Each input word carries a frame of up to eight
// Q1.15 class probabilities and a Q8.8 motion value; each accepted word gives
// exactly one result word with the smoothed (majority-vote) class, the frame
// confidence and the current accumulated final decision. One lane per class
// keeps that class's saturating weighted and plain sums and counts its votes;
// a merging stage walks the lanes one per cycle to find the final class and
// the vote winner, and a serial 64-bit divider normalizes the winning sum,
// one quotient bit per cycle. A clear word or an invalid class count skips
// the lane scan and the divider; a frame before any frame was accumulated
// skips the divider. One frame is processed at a time; the next word is
// taken while the previous result still waits in the output register.
module gesture_score_accumulator_core #(
    parameter int MAX_CLASSES   = gsa_pkg::DEF_MAX_CLASSES,
    parameter int HISTORY_DEPTH = gsa_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // tdata: motion[15:0], prob_0[31:16], prob_1 ... prob_7[143:128]
    input  logic [gsa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: opcode[0]
    input  logic                               s_axis_tuser,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: vote_class[3:0], frame_confidence[19:4], final_valid[20],
    //        final_idx[23:21], final_prob[39:24]
    output logic [gsa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gsa_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam int LW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

    gsa_pkg::t_state r_state, n_state;

    // Configuration registers.
    logic [3:0]  r_num_cls;
    logic [15:0] r_motion_thr;
    logic [15:0] r_min_conf;
    logic        w_cfg_wr;

    // Frame capture and per-frame values.
    logic                    r_opcode;
    logic [15:0]             r_motion;
    logic [7:0][15:0]        r_probs;
    logic [15:0]             r_conf;
    logic [2:0]              r_pred;
    logic [15:0]             r_ad;
    logic [31:0]             r_weight;

    // Shared accumulated state.
    logic [63:0]                  r_wtotal;
    logic [15:0]                  r_used;
    logic [HISTORY_DEPTH-1:0][2:0] r_hist;
    logic [FW-1:0]                r_fill;

    // Merge scan.
    logic [2:0]    r_k;
    logic [63:0]   r_best_num;
    logic [2:0]    r_fc;
    logic [FW-1:0] r_best_vote;
    logic [3:0]    r_smooth;

    // Result and output register.
    logic [3:0]  r_res_smooth;
    logic [15:0] r_res_conf;
    logic        r_res_fvalid;
    logic [2:0]  r_res_fclass;
    logic [15:0] r_res_fprob;
    logic        r_out_valid;
    logic [gsa_pkg::OUT_TDATA_W-1:0] r_out_data;

    // Lane side.
    gsa_pkg::t_lane_ctl w_lane_ctl [MAX_CLASSES];
    logic [63:0]        w_wsum  [MAX_CLASSES];
    logic [31:0]        w_psum  [MAX_CLASSES];
    logic [FW-1:0]      w_votes [MAX_CLASSES];
    logic               w_clr;

    gsa_pkg::t_div_res w_div;
    logic        w_div_start;
    logic [63:0] w_den;
    logic        w_use_w;
    logic [63:0] w_cand;
    logic [63:0] n_best_num;
    logic [2:0]  n_fc;
    logic        w_last;
    logic        w_n_ok;
    logic        w_acc_frame;
    logic        w_vote_frame;

    logic [15:0] n_conf;
    logic [2:0]  n_pred;
    logic [16:0] w_diff;
    logic [16:0] w_abs;
    logic [64:0] w_wt_add;

    // ------------------------------------------------------------------
    // Configuration port. Writes land at the access phase; pready is tied high.
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cls    <= gsa_pkg::RST_CLASS_CNT;
            r_motion_thr <= gsa_pkg::RST_MOTION_THR;
            r_min_conf   <= gsa_pkg::RST_MIN_CONF;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                gsa_pkg::REG_NUM_CLS:    r_num_cls    <= pwdata[3:0];
                gsa_pkg::REG_MOTION_THR: r_motion_thr <= pwdata[15:0];
                gsa_pkg::REG_MIN_CONF:   r_min_conf   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            gsa_pkg::REG_NUM_CLS:    prdata = {28'd0, r_num_cls};
            gsa_pkg::REG_MOTION_THR: prdata = {16'd0, r_motion_thr};
            gsa_pkg::REG_MIN_CONF:   prdata = {16'd0, r_min_conf};
            default:                 prdata = '0;
        endcase
    end

    // A class count write or a clear word wipes all accumulated state.
    assign w_clr = (w_cfg_wr && paddr[3:2] == gsa_pkg::REG_NUM_CLS) ||
                   (r_state == gsa_pkg::S_ARGMAX && r_opcode == gsa_pkg::OP_CLEAR);

    assign w_n_ok = (r_num_cls != 4'd0) && (r_num_cls <= 4'(MAX_CLASSES));

    // ------------------------------------------------------------------
    // Frame argmax (ties to the lower index) and motion distance.
    // ------------------------------------------------------------------
    always_comb begin
        n_conf = r_probs[0];
        n_pred = '0;
        for (int c = 1; c < gsa_pkg::NUM_PROBS; c++) begin
            if (4'(c) < r_num_cls && r_probs[c] > n_conf) begin
                n_conf = r_probs[c];
                n_pred = 3'(c);
            end
        end
    end

    assign w_diff = {r_motion[15], r_motion} - {r_motion_thr[15], r_motion_thr};
    assign w_abs  = w_diff[16] ? (17'd0 - w_diff) : w_diff;

    assign w_acc_frame  = r_conf >= gsa_pkg::HALF_CONF;
    assign w_vote_frame = r_conf >= r_min_conf;
    assign w_wt_add     = {1'b0, r_wtotal} + 65'(r_weight);

    // ------------------------------------------------------------------
    // Class lanes.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < MAX_CLASSES; g++) begin : g_lane
        assign w_lane_ctl[g].clr    = w_clr;
        assign w_lane_ctl[g].mul_en = (r_state == gsa_pkg::S_MUL);
        assign w_lane_ctl[g].acc_en = (r_state == gsa_pkg::S_ACC) && w_acc_frame &&
                                      (4'(g) < r_num_cls);

        gsa_lane #(
            .LANE_IDX      (g),
            .HISTORY_DEPTH (HISTORY_DEPTH)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_lane_ctl[g]),
            .i_prob   (r_probs[g]),
            .i_weight (r_weight),
            .i_hist   (r_hist),
            .i_fill   (r_fill),
            .o_wsum   (w_wsum[g]),
            .o_psum   (w_psum[g]),
            .o_votes  (w_votes[g])
        );
    end

    // ------------------------------------------------------------------
    // Merge scan: one lane per cycle. The weighted sums decide when any
    // weight was accumulated, otherwise the plain sums do.
    // ------------------------------------------------------------------
    assign w_use_w = (r_wtotal != 64'd0);
    assign w_cand  = w_use_w ? w_wsum[r_k[LW-1:0]] : {32'd0, w_psum[r_k[LW-1:0]]};
    assign w_den   = w_use_w ? r_wtotal : {48'd0, r_used};
    assign w_last  = (r_k == 3'(r_num_cls - 4'd1));

    always_comb begin
        n_best_num = r_best_num;
        n_fc       = r_fc;
        if (w_cand > r_best_num) begin
            n_best_num = w_cand;
            n_fc       = r_k;
        end
    end

    assign w_div_start = (r_state == gsa_pkg::S_SCAN) && w_last && (r_used != 16'd0);

    gsa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (n_best_num),
        .i_den   (w_den),
        .o_res   (w_div)
    );

    // ------------------------------------------------------------------
    // Control.
    // ------------------------------------------------------------------
    assign s_axis_tready = (r_state == gsa_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gsa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gsa_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = gsa_pkg::S_ARGMAX;
                end
            end
            gsa_pkg::S_ARGMAX: begin
                if (r_opcode == gsa_pkg::OP_CLEAR || !w_n_ok) begin
                    n_state = gsa_pkg::S_DONE;
                end else begin
                    n_state = gsa_pkg::S_WSQ;
                end
            end
            gsa_pkg::S_WSQ:  n_state = gsa_pkg::S_MUL;
            gsa_pkg::S_MUL:  n_state = gsa_pkg::S_ACC;
            gsa_pkg::S_ACC:  n_state = gsa_pkg::S_SCAN;
            gsa_pkg::S_SCAN: begin
                if (w_last) begin
                    n_state = (r_used != 16'd0) ? gsa_pkg::S_DIV : gsa_pkg::S_DONE;
                end
            end
            gsa_pkg::S_DIV: begin
                if (w_div.done) begin
                    n_state = gsa_pkg::S_DONE;
                end
            end
            gsa_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = gsa_pkg::S_IDLE;
                end
            end
            default: n_state = gsa_pkg::S_IDLE;
        endcase
    end

    // Frame capture and per-frame datapath.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_opcode <= s_axis_tuser;
            r_motion <= s_axis_tdata[15:0];
            for (int c = 0; c < gsa_pkg::NUM_PROBS; c++) begin
                r_probs[c] <= s_axis_tdata[16*c+16 +: 16];
            end
        end
        if (r_state == gsa_pkg::S_ARGMAX) begin
            r_conf <= n_conf;
            r_pred <= n_pred;
            r_ad   <= w_abs[15:0];
        end
        if (r_state == gsa_pkg::S_WSQ) begin
            r_weight <= 32'(r_ad) * 32'(r_ad);
        end
    end

    // Shared accumulated state and history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clr) begin
            r_wtotal <= '0;
            r_used   <= '0;
            r_hist   <= '0;
            r_fill   <= '0;
        end else if (r_state == gsa_pkg::S_ACC) begin
            if (w_acc_frame) begin
                r_wtotal <= w_wt_add[64] ? {64{1'b1}} : w_wt_add[63:0];
                if (r_used != 16'hFFFF) begin
                    r_used <= r_used + 16'd1;
                end
            end
            if (w_vote_frame) begin
                if (r_fill < FW'(HISTORY_DEPTH)) begin
                    for (int i = 0; i < HISTORY_DEPTH; i++) begin
                        if (FW'(i) == r_fill) begin
                            r_hist[i] <= r_pred;
                        end
                    end
                    r_fill <= r_fill + FW'(1);
                end else begin
                    for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                        r_hist[i] <= r_hist[i+1];
                    end
                    r_hist[HISTORY_DEPTH-1] <= r_pred;
                end
            end
        end
    end

    // Scan registers and result fields.
    always_ff @(posedge i_clk) begin
        case (r_state)
            gsa_pkg::S_ARGMAX: begin
                // Clear word or invalid class count: no class, all else zero.
                r_res_smooth <= gsa_pkg::SMOOTH_NONE;
                r_res_conf   <= '0;
                r_res_fvalid <= 1'b0;
                r_res_fclass <= '0;
                r_res_fprob  <= '0;
            end
            gsa_pkg::S_ACC: begin
                r_k         <= '0;
                r_best_num  <= '0;
                r_fc        <= '0;
                r_best_vote <= '0;
                r_smooth    <= gsa_pkg::SMOOTH_NONE;
            end
            gsa_pkg::S_SCAN: begin
                r_k        <= r_k + 3'd1;
                r_best_num <= n_best_num;
                r_fc       <= n_fc;
                if (w_votes[r_k[LW-1:0]] > r_best_vote) begin
                    r_best_vote <= w_votes[r_k[LW-1:0]];
                    r_smooth    <= {1'b0, r_k};
                end
                if (w_last) begin
                    r_res_smooth <= (w_votes[r_k[LW-1:0]] > r_best_vote) ?
                                    {1'b0, r_k} : r_smooth;
                    r_res_conf   <= r_conf;
                    r_res_fvalid <= 1'b0;
                    r_res_fclass <= '0;
                    r_res_fprob  <= '0;
                end
            end
            gsa_pkg::S_DIV: begin
                if (w_div.done) begin
                    r_res_fvalid <= 1'b1;
                    r_res_fclass <= r_fc;
                    r_res_fprob  <= w_div.q;
                end
            end
            default: ;
        endcase
    end

    // Output register: frees the input side while a result waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == gsa_pkg::S_DONE && (!r_out_valid || m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gsa_pkg::S_DONE && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= {r_res_fprob, r_res_fclass, r_res_fvalid, r_res_conf, r_res_smooth};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
endmodule

/* design/gsa_checker.sv */
// Port-level checks for the gesture score accumulator.
module gsa_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [gsa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic                               pready
);
    // A stalled result word holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // The smoothed class is either a class index or the no-class code.
    a_smooth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3] == 1'b0 || m_axis_tdata[3:0] == 4'hF))
        else $error("smoothed class out of range");

    // Without an accumulated frame the final fields are zero.
    a_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[20] |-> m_axis_tdata[39:21] == 19'd0)
        else $error("final fields set without a valid decision");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("configuration port not ready");

    // The block never takes a word on the same edge a fresh result appears.
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared right after accept");
endmodule

bind gesture_score_accumulator_core gsa_checker u_gsa_checker (.*);

/* dv/gesture_score_accumulator_core_tb.sv */
`timescale 1ns / 1ps

module gesture_score_accumulator_core_tb;

    // One decoded result word, fields in their natural widths.
    typedef struct {
        logic [3:0]  smoothed;
        logic [15:0] conf;
        logic        fvalid;
        logic [2:0]  fclass;
        logic [15:0] fprob;
    } t_result;

    // Predicts the block's result words and holds them until they come out.
    class gesture_scoreboard;
        logic [3:0]  n_classes;
        logic [15:0] thr;
        logic [15:0] min_conf;
        logic [63:0] wsum [8];
        logic [31:0] psum [8];
        logic [63:0] wtot;
        logic [15:0] nframes;
        logic [2:0]  votes [8];
        int          nvotes;
        t_result     pending [$];
        int          errors;

        function void clear_all();
            for (int c = 0; c < 8; c++) begin
                wsum[c] = '0;
                psum[c] = '0;
                votes[c] = '0;
            end
            wtot = '0;
            nframes = '0;
            nvotes = 0;
        endfunction

        function void reset_regs();
            n_classes = gsa_pkg::RST_CLASS_CNT;
            thr = gsa_pkg::RST_MOTION_THR;
            min_conf = gsa_pkg::RST_MIN_CONF;
            clear_all();
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                gsa_pkg::REG_NUM_CLS: begin
                    n_classes = val[3:0];
                    clear_all();
                end
                gsa_pkg::REG_MOTION_THR: thr = val[15:0];
                gsa_pkg::REG_MIN_CONF:   min_conf = val[15:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] add64(logic [63:0] a, logic [63:0] b);
            logic [64:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[64] ? '1 : s[63:0];
        endfunction

        // Works out the result word caused by one accepted input word.
        function void note_frame(logic op, logic [143:0] data);
            t_result r;
            logic [15:0] p [8];
            logic [15:0] best;
            logic [2:0]  pred;
            int          d;
            logic [63:0] w;
            logic [32:0] ps;
            int          cnt [8];
            int          top;
            logic [63:0] num, den, q;
            r = '{gsa_pkg::SMOOTH_NONE, 16'd0, 1'b0, 3'd0, 16'd0};
            if (op == gsa_pkg::OP_CLEAR) begin
                clear_all();
                pending.push_back(r);
                return;
            end
            if (n_classes == 0 || n_classes > 8) begin
                pending.push_back(r);
                return;
            end
            for (int c = 0; c < 8; c++) p[c] = data[16 + 16*c +: 16];
            best = p[0];
            pred = 0;
            for (int c = 1; c < n_classes; c++)
                if (p[c] > best) begin
                    best = p[c];
                    pred = c[2:0];
                end
            if (best >= gsa_pkg::HALF_CONF) begin
                d = int'($signed(data[15:0])) - int'($signed(thr));
                if (d < 0) d = -d;
                w = 64'(d) * 64'(d);
                for (int c = 0; c < n_classes; c++) begin
                    wsum[c] = add64(wsum[c], 64'(p[c]) * w);
                    ps = {1'b0, psum[c]} + 33'(p[c]);
                    psum[c] = ps[32] ? '1 : ps[31:0];
                end
                wtot = add64(wtot, w);
                if (nframes != 16'hFFFF) nframes++;
            end
            if (best >= min_conf) begin
                if (nvotes < 8) begin
                    votes[nvotes] = pred;
                    nvotes++;
                end else begin
                    for (int i = 0; i < 7; i++) votes[i] = votes[i + 1];
                    votes[7] = pred;
                end
            end
            if (nvotes > 0) begin
                for (int c = 0; c < 8; c++) cnt[c] = 0;
                for (int i = 0; i < nvotes; i++)
                    if (votes[i] < n_classes) cnt[votes[i]]++;
                top = 0;
                for (int c = 0; c < n_classes; c++)
                    if (cnt[c] > top) begin
                        top = cnt[c];
                        r.smoothed = c[3:0];
                    end
            end
            r.conf = best;
            if (nframes > 0) begin
                r.fvalid = 1'b1;
                if (wtot != 0) begin
                    num = wsum[0];
                    for (int c = 1; c < n_classes; c++)
                        if (wsum[c] > num) begin
                            num = wsum[c];
                            r.fclass = c[2:0];
                        end
                    den = wtot;
                end else begin
                    num = 64'(psum[0]);
                    for (int c = 1; c < n_classes; c++)
                        if (64'(psum[c]) > num) begin
                            num = 64'(psum[c]);
                            r.fclass = c[2:0];
                        end
                    den = 64'(nframes);
                end
                q = num / den;
                r.fprob = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
            end
            pending.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_word(logic [39:0] word);
            t_result e;
            if (pending.size() == 0) begin
                report("unexpected word", word[31:0], 0);
                return;
            end
            e = pending.pop_front();
            if (word[3:0] !== e.smoothed)
                report("vote_class", 32'(word[3:0]), 32'(e.smoothed));
            if (word[19:4] !== e.conf)
                report("frame_confidence", 32'(word[19:4]), 32'(e.conf));
            if (word[20] !== e.fvalid)
                report("final_valid", 32'(word[20]), 32'(e.fvalid));
            if (word[23:21] !== e.fclass)
                report("final_idx", 32'(word[23:21]), 32'(e.fclass));
            if (word[39:24] !== e.fprob)
                report("final_prob", 32'(word[39:24]), 32'(e.fprob));
        endtask
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic [143:0]               s_axis_tdata;
    logic                       s_axis_tuser;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [39:0]                m_axis_tdata;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic                       psel, penable, pwrite;
    logic [gsa_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    gesture_score_accumulator_core dut (.*);

    gesture_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  quiet_cycles;
    bit  timed_out;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls at random; every word taken goes to the checker.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: the receiver may stall for long stretches, so the run is ended
    // as a hang only once the quiet-cycle count reaches its limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == 5000) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // A register write is a setup phase followed by an access phase.
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Sends one word, holding it until the block takes it. Valid stays up
    // after the handshake so that the next word can follow without a gap.
    task automatic send_word(logic op, logic [143:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_frame(op, data);
    endtask

    // Drains outstanding results, then lets the block settle before a write.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_prob();
        case ($urandom_range(5))
            0: return 16'd32768;
            1: return 16'($urandom_range(32768, 16384));
            2: return 16'($urandom_range(16383));
            3: return 16'($urandom);
            default: return 16'($urandom_range(20000));
        endcase
    endfunction

    // A frame with a random motion value and an independently drawn probability per class.
    function automatic logic [143:0] rand_frame();
        logic [143:0] f;
        f[15:0] = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2048));
        if ($urandom_range(1)) f[15:0] = -f[15:0];
        for (int c = 0; c < 8; c++) f[16 + 16*c +: 16] = rand_prob();
        return f;
    endfunction

    function automatic logic [143:0] flat_frame(logic [15:0] m, logic [15:0] p);
        logic [143:0] f;
        f[15:0] = m;
        for (int c = 0; c < 8; c++) f[16 + 16*c +: 16] = p;
        return f;
    endfunction

    task automatic random_phase(int count);
        for (int k = 0; k < count; k++)
            send_word(($urandom_range(40) == 0) ? gsa_pkg::OP_CLEAR : gsa_pkg::OP_FRAME,
                      rand_frame());
    endtask

    initial begin
        logic [143:0] f;
        sb = new();
        sb.reset_regs();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 36;
        recv_idle_pct = 73;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ties, full-scale and zero probabilities, extreme motion,
        // clear opcode, a full history shifting out its oldest entry.
        send_word(gsa_pkg::OP_FRAME, flat_frame(16'h7FFF, 16'd32768));
        send_word(gsa_pkg::OP_FRAME, flat_frame(16'h8000, 16'd0));
        send_word(gsa_pkg::OP_FRAME, flat_frame(16'h0000, 16'd16384));
        send_word(gsa_pkg::OP_FRAME, flat_frame(16'h0000, 16'd16383));
        send_word(gsa_pkg::OP_FRAME, flat_frame(16'hFFFF, 16'hFFFF));
        for (int c = 0; c < 10; c++) begin
            f = flat_frame(16'h8000, 16'd100);
            f[16 + 16*(c % 8) +: 16] = 16'd30000;
            send_word(gsa_pkg::OP_FRAME, f);
        end
        send_word(gsa_pkg::OP_CLEAR, flat_frame(16'hFFFF, 16'hFFFF));
        send_word(gsa_pkg::OP_FRAME, flat_frame(16'h0000, 16'd32768));
        drain();

        // Zero motion weight against the threshold: plain sums decide.
        write_reg(gsa_pkg::REG_MOTION_THR, 32'h0000_8000);
        write_reg(gsa_pkg::REG_MIN_CONF, 32'd0);
        send_word(gsa_pkg::OP_FRAME, flat_frame(16'h8000, 16'd20000));
        send_word(gsa_pkg::OP_FRAME, flat_frame(16'h7FFF, 16'd0));
        drain();

        // An invalid class count answers with an empty result.
        write_reg(gsa_pkg::REG_NUM_CLS, 32'd0);
        send_word(gsa_pkg::OP_FRAME, flat_frame(16'h1234, 16'd32768));
        drain();
        write_reg(gsa_pkg::REG_NUM_CLS, 32'd15);
        send_word(gsa_pkg::OP_FRAME, flat_frame(16'h1234, 16'd32768));
        drain();

        write_reg(gsa_pkg::REG_NUM_CLS, 32'd1);
        write_reg(gsa_pkg::REG_MOTION_THR, 32'h0000_7FFF);
        write_reg(gsa_pkg::REG_MIN_CONF, 32'd32768);
        random_phase(120);
        drain();

        write_reg(gsa_pkg::REG_NUM_CLS, 32'd3);
        write_reg(gsa_pkg::REG_MOTION_THR, 32'h0000_FF00);
        write_reg(gsa_pkg::REG_MIN_CONF, 32'd20000);
        random_phase(130);
        drain();

        send_idle_pct = 73;
        recv_idle_pct = 36;
        write_reg(gsa_pkg::REG_NUM_CLS, 32'd8);
        write_reg(gsa_pkg::REG_MOTION_THR, 32'd0);
        write_reg(gsa_pkg::REG_MIN_CONF, 32'd16384);
        random_phase(250);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(gsa_pkg::REG_NUM_CLS, 32'd5);
        write_reg(gsa_pkg::REG_MOTION_THR, 32'h0000_0100);
        write_reg(gsa_pkg::REG_MIN_CONF, 32'd8000);
        random_phase(250);
        drain();

        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
